>>> design/mtks_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtks_pkg: shared types for the multi-table key store
// Beat formats, command and status codes, the search token that walks
// the cell chain, and the write broadcast from the controller.
// ---------------------------------------------------------------------------
package mtks_pkg;

  // Command codes carried in the cmd field.
  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_CHANGE = 3'd3,
    CMD_CLEAR  = 3'd4
  } mtks_cmd_e;

  // Status codes returned with every result beat.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TABLE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUP       = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_BAD_POS   = 3'd5
  } mtks_status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } mtks_state_e;

  // Input beat.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  table_sel;
    logic [15:0] key;
    logic [63:0] entry_name;
    logic [3:0]  position;
  } mtks_in_t;

  // Result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] found_name;
    logic [15:0] found_key;
  } mtks_out_t;

  // Search token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic        valid;
    logic [1:0]  tbl;
    logic [15:0] key;
    logic [3:0]  pos;
    logic        hit;         // some live slot holds key
    logic        dup;         // a live slot other than pos holds key
    logic [15:0] last_key;    // key of slot count-1
    logic [63:0] last_name;   // name of slot count-1
    logic [63:0] found_name;  // name of the first matching slot
  } mtks_tok_t;

  // Write broadcast to all cells; the cell whose slot matches takes it.
  typedef struct packed {
    logic        en;
    logic        key_only;
    logic [1:0]  tbl;
    logic [15:0] key;
    logic [63:0] name;
  } mtks_wr_t;

endpackage

>>> design/mtks_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mtks_cell: one slot position of every table
// Holds the key and name of slot IDX for each table, compares the passing
// search token against its entry and forwards the token to the next cell.
// ---------------------------------------------------------------------------
module mtks_cell
  import mtks_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int TABLES     = 4,
  parameter int ENTRIES    = 16,
  parameter int NAME_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mtks_tok_t                           tok_in,
  input  logic [$clog2(ENTRIES+1)-1:0]        cnt_in,
  input  logic [$clog2(ENTRIES)-1:0]          hidx_in,
  input  mtks_wr_t                            wr,
  input  logic [$clog2(ENTRIES)-1:0]          wr_idx,
  output mtks_tok_t                           tok_out,
  output logic [$clog2(ENTRIES+1)-1:0]        cnt_out,
  output logic [$clog2(ENTRIES)-1:0]          hidx_out
);

  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int TBL_W  = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int NAME_W = NAME_BYTES * 8;
  localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;

  logic [15:0]       key_mem_r  [TABLES];
  logic [NAME_W-1:0] name_mem_r [TABLES];

  mtks_tok_t         tok_r, tok_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  hidx_r, hidx_nxt;

  logic [15:0]       key_rd;
  logic [NAME_W-1:0] name_rd;
  logic              live;
  logic              is_last;
  logic              match;

  // Read this slot of the table the token addresses.
  assign key_rd  = key_mem_r[TBL_W'(tok_in.tbl)];
  assign name_rd = name_mem_r[TBL_W'(tok_in.tbl)];

  // Compare and update the token; the first match in slot order wins.
  always_comb begin
    tok_nxt  = tok_in;
    hidx_nxt = hidx_in;
    live     = CNT_W'(IDX) < cnt_in;
    is_last  = CNT_W'(IDX + 1) == cnt_in;
    match    = tok_in.valid && live && (key_rd == tok_in.key);
    if (match && !tok_in.hit) begin
      tok_nxt.hit        = 1'b1;
      tok_nxt.found_name = 64'(name_rd);
      hidx_nxt           = IDX_W'(IDX);
    end
    if (match && (CMP_W'(tok_in.pos) != CMP_W'(IDX))) begin
      tok_nxt.dup = 1'b1;
    end
    if (tok_in.valid && is_last) begin
      tok_nxt.last_key  = key_rd;
      tok_nxt.last_name = 64'(name_rd);
    end
  end

  // Token stage; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_in;
    hidx_r <= hidx_nxt;
  end

  // Entry storage, written by the controller's broadcast.
  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == IDX_W'(IDX))) begin
      key_mem_r[TBL_W'(wr.tbl)] <= wr.key;
      if (!wr.key_only) begin
        name_mem_r[TBL_W'(wr.tbl)] <= NAME_W'(wr.name);
      end
    end
  end

  assign tok_out  = tok_r;
  assign cnt_out  = cnt_r;
  assign hidx_out = hidx_r;

endmodule

>>> design/multi_table_key_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_table_key_store: several small (id, name) tables with linear search
// A search token walks a chain of ENTRIES cells, one slot per cell, then the
// controller decides the status, broadcasts any write and updates counts.
// ---------------------------------------------------------------------------
//
//  Channel  | Ports                            | Beat
//  ---------+----------------------------------+---------------------------
//  input    | in_valid, in_stall, in_data      | one command
//  result   | out_valid, out_stall, out_data   | status, found name and id
//  config   | cfg_wr_en, cfg_wr_data           | tables_in_use
//
//  Every command passes its token through the ENTRIES cells of the chain, the
//  controller captures it at the end of the chain, and the commit then writes
//  the entry and loads the result register before the next beat is accepted.
//  Commands are taken one at a time; in_stall is high from acceptance until
//  the commit. A stalled result holds the commit back, not the search.
//  Reset clears all entry counts and sets tables_in_use to 4; entry storage
//  is not cleared.
// ---------------------------------------------------------------------------
module multi_table_key_store
  import mtks_pkg::*;
#(
  parameter int TABLES     = 4,
  parameter int ENTRIES    = 16,
  parameter int NAME_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  mtks_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output mtks_out_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int TBL_W = (TABLES > 1) ? $clog2(TABLES) : 1;
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [4:0] TABLES_L = 5'(TABLES);

  mtks_state_e       state_r, state_nxt;
  logic [2:0]        tables_r;
  logic [CNT_W-1:0]  cnt_r [TABLES];
  logic [2:0]        cmd_r;
  logic [63:0]       name_in_r;

  mtks_tok_t         fin_tok_r;
  logic [CNT_W-1:0]  fin_cnt_r;
  logic [IDX_W-1:0]  fin_hidx_r;

  mtks_out_t         out_r, out_nxt;
  logic              out_valid_r;

  mtks_tok_t         tok_w  [ENTRIES+1];
  logic [CNT_W-1:0]  cnt_w  [ENTRIES+1];
  logic [IDX_W-1:0]  hidx_w [ENTRIES+1];

  logic              inject, latch, commit, out_free;
  logic              head_ok;
  logic [CNT_W-1:0]  head_cnt;
  logic [4:0]        limit;
  logic              tbl_ok;
  logic [TBL_W-1:0]  fin_tidx;
  mtks_wr_t          wr;
  logic [IDX_W-1:0]  wr_idx;
  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_val;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tables_r <= 3'd4;
    end else if (cfg_wr_en) begin
      tables_r <= cfg_wr_data;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid)         state_nxt = S_SCAN;
      S_SCAN:  if (tok_w[ENTRIES].valid) state_nxt = S_DONE;
      S_DONE:  if (out_free)         state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Controller outputs.
  assign out_free = !out_valid_r || !out_stall;
  always_comb begin
    inject   = (state_r == S_IDLE) && in_valid;
    in_stall = (state_r != S_IDLE);
    latch    = (state_r == S_SCAN) && tok_w[ENTRIES].valid;
    commit   = (state_r == S_DONE) && out_free;
  end

  // Build the head token from the accepted beat.
  assign head_ok  = {3'b000, in_data.table_sel} < TABLES_L;
  assign head_cnt = head_ok ? cnt_r[TBL_W'(in_data.table_sel)] : '0;

  always_comb begin
    tok_w[0]            = '0;
    tok_w[0].valid      = inject;
    tok_w[0].tbl        = in_data.table_sel;
    tok_w[0].key        = in_data.key;
    tok_w[0].pos        = in_data.position;
    cnt_w[0]            = head_cnt;
    hidx_w[0]           = '0;
  end

  always_ff @(posedge clk) begin
    if (inject) begin
      cmd_r     <= in_data.cmd;
      name_in_r <= in_data.entry_name;
    end
  end

  // Cell chain, one slot per cell.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    mtks_cell #(
      .IDX        (g),
      .TABLES     (TABLES),
      .ENTRIES    (ENTRIES),
      .NAME_BYTES (NAME_BYTES)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   (tok_w[g]),
      .cnt_in   (cnt_w[g]),
      .hidx_in  (hidx_w[g]),
      .wr       (wr),
      .wr_idx   (wr_idx),
      .tok_out  (tok_w[g+1]),
      .cnt_out  (cnt_w[g+1]),
      .hidx_out (hidx_w[g+1])
    );
  end

  // Capture the token leaving the chain.
  always_ff @(posedge clk) begin
    if (latch) begin
      fin_tok_r  <= tok_w[ENTRIES];
      fin_cnt_r  <= cnt_w[ENTRIES];
      fin_hidx_r <= hidx_w[ENTRIES];
    end
  end

  // Decide status, write and count update for the finished command.
  assign limit    = ({2'b00, tables_r} > TABLES_L) ? TABLES_L : {2'b00, tables_r};
  assign tbl_ok   = {3'b000, fin_tok_r.tbl} < limit;
  assign fin_tidx = TBL_W'(fin_tok_r.tbl);

  always_comb begin
    out_nxt        = '0;
    out_nxt.status = ST_OK;
    wr             = '0;
    wr.tbl         = fin_tok_r.tbl;
    wr_idx         = '0;
    cnt_we         = 1'b0;
    cnt_val        = fin_cnt_r;
    if (cmd_r <= CMD_CLEAR && !tbl_ok) begin
      out_nxt.status = ST_BAD_TABLE;
    end else begin
      unique case (cmd_r)
        CMD_ADD: begin
          if (fin_cnt_r == CNT_W'(ENTRIES)) begin
            out_nxt.status = ST_FULL;
          end else if (fin_tok_r.hit) begin
            out_nxt.status = ST_DUP;
          end else begin
            wr.en   = commit;
            wr.key  = fin_tok_r.key;
            wr.name = name_in_r;
            wr_idx  = IDX_W'(fin_cnt_r);
            cnt_we  = commit;
            cnt_val = fin_cnt_r + CNT_W'(1);
          end
        end
        CMD_DELETE: begin
          if (!fin_tok_r.hit) begin
            out_nxt.status = ST_NOT_FOUND;
          end else begin
            // Move the last entry into the vacated slot.
            wr.en   = commit;
            wr.key  = fin_tok_r.last_key;
            wr.name = fin_tok_r.last_name;
            wr_idx  = fin_hidx_r;
            cnt_we  = commit;
            cnt_val = fin_cnt_r - CNT_W'(1);
          end
        end
        CMD_LOOKUP: begin
          if (!fin_tok_r.hit) begin
            out_nxt.status = ST_NOT_FOUND;
          end else begin
            out_nxt.found_name = fin_tok_r.found_name;
            out_nxt.found_key  = fin_tok_r.key;
          end
        end
        CMD_CHANGE: begin
          if (CMP_W'(fin_tok_r.pos) >= CMP_W'(fin_cnt_r)) begin
            out_nxt.status = ST_BAD_POS;
          end else if (fin_tok_r.dup) begin
            out_nxt.status = ST_DUP;
          end else begin
            wr.en       = commit;
            wr.key_only = 1'b1;
            wr.key      = fin_tok_r.key;
            wr_idx      = IDX_W'(fin_tok_r.pos);
          end
        end
        CMD_CLEAR: begin
          cnt_we  = commit;
          cnt_val = '0;
        end
        default: begin
          out_nxt.status = ST_OK;
        end
      endcase
    end
  end

  // Entry counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TABLES; t++) begin
        cnt_r[t] <= '0;
      end
    end else if (cnt_we) begin
      cnt_r[fin_tidx] <= cnt_val;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // An accepted beat enters the first cell on the next cycle.
  a_inject: assert property (@(posedge clk) disable iff (!rst_n)
    inject |=> tok_w[1].valid)
    else $error("accepted beat did not enter the cell chain");

  // A token leaves the chain only while the controller is scanning.
  a_tail: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[ENTRIES].valid |-> state_r == S_SCAN)
    else $error("token left the chain outside the scan state");

  // A commit always presents a result.
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("commit did not load the result register");

  // The count of the table addressed by the input beat never exceeds the table depth.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    head_cnt <= CNT_W'(ENTRIES))
    else $error("entry count above table depth");

endmodule
